/* sv/hrhe_pkg.sv */
// shared types, constants and keyword tables for the http response header extractor
// no dependencies; every other file except hrhe_in_if imports this package
package hrhe_pkg;

    // widths of the result fields
    localparam int ST_W         = 32;
    localparam int LEN_W        = 64;
    localparam int OUT_POS_W    = 32;
    localparam int POS_BITS_DEF = 32;

    typedef logic [OUT_POS_W-1:0] t_out_pos;

    // keyword lengths
    localparam int STATUS_KW_LEN = 8;
    localparam int LENGTH_KW_LEN = 16;
    localparam int LOC_KW_LEN    = 9;

    // saturation limits of the number accumulators
    localparam logic [ST_W-1:0]  ST_LIMIT   = 32'h8000_0000;
    localparam logic [ST_W-1:0]  ST_MAX     = 32'h7FFF_FFFF;
    localparam logic [LEN_W-1:0] LEN_LIMIT  = 64'h8000_0000_0000_0000;
    localparam logic [LEN_W-1:0] LEN_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ST_W-1:0]  ST_REDIRECT = 32'd302;

    // character codes
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {ST_MATCH, ST_SKIP, ST_SIGN, ST_DIGITS} t_st_phase;
    typedef enum logic [2:0] {LN_MATCH, LN_SKIP, LN_SIGN, LN_DIGITS, LN_DONE} t_len_phase;
    typedef enum logic [1:0] {LC_MATCH, LC_SKIP, LC_VALUE, LC_DONE} t_loc_phase;

    // one byte step handed from the input register to the parsers
    typedef struct packed {
        logic       en;
        logic       clr;
        logic [7:0] data;
    } t_step;

    // location tracker state summary after the current byte
    typedef struct packed {
        logic active;
        logic skipping;
    } t_loc_flags;

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // "HTTP/1.1"
    function automatic logic [7:0] kw_status(input logic [2:0] idx);
        case (idx)
            3'd0:    kw_status = 8'h48;
            3'd1:    kw_status = 8'h54;
            3'd2:    kw_status = 8'h54;
            3'd3:    kw_status = 8'h50;
            3'd4:    kw_status = 8'h2F;
            3'd5:    kw_status = 8'h31;
            3'd6:    kw_status = 8'h2E;
            default: kw_status = 8'h31;
        endcase
    endfunction

    // "Content-Length: "
    function automatic logic [7:0] kw_length(input logic [3:0] idx);
        case (idx)
            4'd0:    kw_length = 8'h43;
            4'd1:    kw_length = 8'h6F;
            4'd2:    kw_length = 8'h6E;
            4'd3:    kw_length = 8'h74;
            4'd4:    kw_length = 8'h65;
            4'd5:    kw_length = 8'h6E;
            4'd6:    kw_length = 8'h74;
            4'd7:    kw_length = 8'h2D;
            4'd8:    kw_length = 8'h4C;
            4'd9:    kw_length = 8'h65;
            4'd10:   kw_length = 8'h6E;
            4'd11:   kw_length = 8'h67;
            4'd12:   kw_length = 8'h74;
            4'd13:   kw_length = 8'h68;
            4'd14:   kw_length = 8'h3A;
            default: kw_length = 8'h20;
        endcase
    endfunction

    // "Location:"
    function automatic logic [7:0] kw_loc(input logic [3:0] idx);
        case (idx)
            4'd0:    kw_loc = 8'h4C;
            4'd1:    kw_loc = 8'h6F;
            4'd2:    kw_loc = 8'h63;
            4'd3:    kw_loc = 8'h61;
            4'd4:    kw_loc = 8'h74;
            4'd5:    kw_loc = 8'h69;
            4'd6:    kw_loc = 8'h6F;
            4'd7:    kw_loc = 8'h6E;
            4'd8:    kw_loc = 8'h3A;
            default: kw_loc = 8'h00;
        endcase
    endfunction

endpackage

/* sv/hrhe_in_if.sv */
// request channel carrying one response byte and its last-byte mark
// depends on nothing but the valid/ready handshake convention
interface hrhe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* sv/hrhe_out_if.sv */
// result channel carrying the extracted header fields of one response
// depends on hrhe_pkg for field widths
interface hrhe_out_if;
    import hrhe_pkg::*;

    logic                  valid;
    logic                  ready;
    logic signed [ST_W-1:0]  resp_status;
    logic signed [LEN_W-1:0] content_length;
    logic                  location_found;
    logic [OUT_POS_W-1:0]  location_offset;
    logic [OUT_POS_W-1:0]  location_length;

    modport source (output valid, output resp_status, output content_length,
                    output location_found, output location_offset,
                    output location_length, input ready);
    modport sink   (input valid, input resp_status, input content_length,
                    input location_found, input location_offset,
                    input location_length, output ready);
endinterface

/* sv/hrhe_status.sv */
// status line parser: matches "HTTP/1.1", then reads sign and digits into the status
// depends on hrhe_pkg
module hrhe_status (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hrhe_pkg::t_step            i_step,
    output logic [hrhe_pkg::ST_W-1:0]  o_value
);
    import hrhe_pkg::*;

    t_st_phase        r_phase, n_phase;
    logic [2:0]       r_idx, n_idx;
    logic [ST_W-1:0]  r_acc, n_acc;
    logic             r_neg, n_neg;
    logic [ST_W-1:0]  r_value, n_value;

    logic [ST_W-1:0]  acc_base;
    logic [ST_W+3:0]  acc_prod;
    logic [2:0]       match_idx;
    logic [3:0]       match_next;
    logic             is_sign;

    // next state for one byte
    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_acc      = r_acc;
        n_neg      = r_neg;
        n_value    = r_value;
        is_sign    = (i_step.data == CH_PLUS) || (i_step.data == CH_MINUS);
        acc_base   = (r_phase == ST_DIGITS) ? r_acc : '0;
        acc_prod   = ({4'b0000, acc_base} << 3) + ({4'b0000, acc_base} << 1)
                   + {{(ST_W){1'b0}}, i_step.data[3:0]};
        match_idx  = (r_phase == ST_MATCH) ? r_idx : 3'd0;
        match_next = 4'd0;
        if (i_step.data == kw_status(match_idx)) begin
            match_next = {1'b0, match_idx} + 4'd1;
        end else if (i_step.data == kw_status(3'd0)) begin
            match_next = 4'd1;
        end

        if (r_phase == ST_SKIP && i_step.data == CH_SP) begin
            // spaces before the number are skipped
        end else if (r_phase == ST_SKIP && is_sign) begin
            n_neg   = (i_step.data == CH_MINUS);
            n_phase = ST_SIGN;
        end else if (r_phase != ST_MATCH && is_digit(i_step.data)) begin
            n_phase = ST_DIGITS;
            n_acc   = (acc_prod > {4'b0000, ST_LIMIT}) ? ST_LIMIT : acc_prod[ST_W-1:0];
            if (r_neg) begin
                n_value = ~n_acc + 1'b1;
            end else begin
                n_value = n_acc[ST_W-1] ? ST_MAX : n_acc;
            end
        end else if (match_next == 4'(STATUS_KW_LEN)) begin
            n_idx   = 3'd0;
            n_phase = ST_SKIP;
            n_neg   = 1'b0;
            n_acc   = '0;
        end else begin
            n_idx   = match_next[2:0];
            n_phase = ST_MATCH;
        end
    end

    // state registers; status value survives the end of a response
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ST_MATCH;
            r_idx   <= 3'd0;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_value <= '0;
        end else if (i_step.en) begin
            r_value <= n_value;
            if (i_step.clr) begin
                r_phase <= ST_MATCH;
                r_idx   <= 3'd0;
                r_acc   <= '0;
                r_neg   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_idx   <= n_idx;
                r_acc   <= n_acc;
                r_neg   <= n_neg;
            end
        end
    end

    assign o_value = n_value;

endmodule

/* sv/hrhe_length.sv */
// content length parser: first "Content-Length: " then sign and digits, 64-bit saturating
// depends on hrhe_pkg
module hrhe_length (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hrhe_pkg::t_step             i_step,
    output logic [hrhe_pkg::LEN_W-1:0]  o_length
);
    import hrhe_pkg::*;

    t_len_phase        r_phase, n_phase;
    logic [3:0]        r_idx, n_idx;
    logic [LEN_W-1:0]  r_acc, n_acc;
    logic              r_neg, n_neg;

    logic [LEN_W+3:0]  acc_prod;
    logic [4:0]        match_next;
    logic              is_sign;

    // next state for one byte
    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_acc      = r_acc;
        n_neg      = r_neg;
        is_sign    = (i_step.data == CH_PLUS) || (i_step.data == CH_MINUS);
        acc_prod   = ({4'b0000, r_acc} << 3) + ({4'b0000, r_acc} << 1)
                   + {{(LEN_W){1'b0}}, i_step.data[3:0]};
        match_next = 5'd0;
        if (i_step.data == kw_length(r_idx)) begin
            match_next = {1'b0, r_idx} + 5'd1;
        end else if (i_step.data == kw_length(4'd0)) begin
            match_next = 5'd1;
        end

        case (r_phase)
            LN_MATCH: begin
                if (match_next == 5'(LENGTH_KW_LEN)) begin
                    n_phase = LN_SKIP;
                end else begin
                    n_idx = match_next[3:0];
                end
            end
            LN_SKIP, LN_SIGN, LN_DIGITS: begin
                if (r_phase == LN_SKIP && i_step.data == CH_SP) begin
                    // leading spaces
                end else if (r_phase == LN_SKIP && is_sign) begin
                    n_neg   = (i_step.data == CH_MINUS);
                    n_phase = LN_SIGN;
                end else if (is_digit(i_step.data)) begin
                    n_phase = LN_DIGITS;
                    n_acc   = (acc_prod > {4'b0000, LEN_LIMIT}) ? LEN_LIMIT
                                                                 : acc_prod[LEN_W-1:0];
                end else begin
                    n_phase = LN_DONE;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= LN_MATCH;
            r_idx   <= 4'd0;
            r_acc   <= '0;
            r_neg   <= 1'b0;
        end else if (i_step.en) begin
            if (i_step.clr) begin
                r_phase <= LN_MATCH;
                r_idx   <= 4'd0;
                r_acc   <= '0;
                r_neg   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_idx   <= n_idx;
                r_acc   <= n_acc;
                r_neg   <= n_neg;
            end
        end
    end

    // signed view of the length after this byte
    assign o_length = n_neg ? (~n_acc + 1'b1) : (n_acc[LEN_W-1] ? LEN_MAX : n_acc);

endmodule

/* sv/hrhe_location.sv */
// location tracker: finds "Location:", records value start and length up to CRLF
// depends on hrhe_pkg
module hrhe_location #(
    parameter int POSITION_BITS = hrhe_pkg::POS_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  hrhe_pkg::t_step           i_step,
    input  logic [POSITION_BITS-1:0]  i_pos,
    output hrhe_pkg::t_loc_flags      o_flags,
    output logic [POSITION_BITS-1:0]  o_start,
    output logic [POSITION_BITS-1:0]  o_count
);
    import hrhe_pkg::*;

    t_loc_phase                r_phase, n_phase;
    logic [3:0]                r_idx, n_idx;
    logic [POSITION_BITS-1:0]  r_start, n_start;
    logic [POSITION_BITS-1:0]  r_count, n_count;
    logic                      r_cr, n_cr;

    logic [3:0]                match_next;

    // next state for one byte
    always_comb begin
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_start    = r_start;
        n_count    = r_count;
        n_cr       = r_cr;
        match_next = 4'd0;
        if (i_step.data == kw_loc(r_idx)) begin
            match_next = r_idx + 4'd1;
        end else if (i_step.data == kw_loc(4'd0)) begin
            match_next = 4'd1;
        end

        case (r_phase)
            LC_MATCH: begin
                if (match_next == 4'(LOC_KW_LEN)) begin
                    n_phase = LC_SKIP;
                end else begin
                    n_idx = match_next;
                end
            end
            LC_SKIP: begin
                // first non-space byte opens the value and counts as one byte of it
                if (i_step.data != CH_SP) begin
                    n_start = i_pos;
                    n_count = POSITION_BITS'(1);
                    n_cr    = (i_step.data == CH_CR);
                    n_phase = LC_VALUE;
                end
            end
            LC_VALUE: begin
                if (r_cr && i_step.data == CH_LF) begin
                    n_count = (r_count != '0) ? r_count - 1'b1 : r_count;
                    n_cr    = 1'b0;
                    n_phase = LC_DONE;
                end else begin
                    n_count = (&r_count) ? r_count : r_count + 1'b1;
                    n_cr    = (i_step.data == CH_CR);
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= LC_MATCH;
            r_idx   <= 4'd0;
            r_start <= '0;
            r_count <= '0;
            r_cr    <= 1'b0;
        end else if (i_step.en) begin
            if (i_step.clr) begin
                r_phase <= LC_MATCH;
                r_idx   <= 4'd0;
                r_start <= '0;
                r_count <= '0;
                r_cr    <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_idx   <= n_idx;
                r_start <= n_start;
                r_count <= n_count;
                r_cr    <= n_cr;
            end
        end
    end

    assign o_flags.active   = (n_phase != LC_MATCH);
    assign o_flags.skipping = (n_phase == LC_SKIP);
    assign o_start          = n_start;
    assign o_count          = n_count;

endmodule

/* sv/http_response_header_extractor.sv */
// HTTP response header extractor, top level; uses hrhe_pkg, hrhe_in_if, hrhe_out_if,
// hrhe_status, hrhe_length and hrhe_location. Bytes of a response enter on i_req one
// per cycle with last_byte on the final one; each byte is registered, then the three
// keyword parsers update their state from the input register, and the byte carrying
// last_byte loads the result register in the same cycle, that drives o_rsp. Throughput
// is one byte per cycle, bounded by the 64-bit multiply-by-ten-and-add of the length
// parser; the input stalls only while a finished result waits in the result register
// and another last byte is ready to overwrite it. The status code is kept from one
// response to the next; all other state clears after each last byte. Positions and
// counts saturate at 2^POSITION_BITS-1 and are reported in their low 32 bits.
module http_response_header_extractor #(
    parameter int POSITION_BITS = hrhe_pkg::POS_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hrhe_in_if.sink       i_req,
    hrhe_out_if.source    o_rsp
);
    import hrhe_pkg::*;

    // input register
    logic                      r_in_valid;
    logic [7:0]                r_in_data;
    logic                      r_in_last;

    // byte position within the response
    logic [POSITION_BITS-1:0]  r_pos, n_pos;

    // result register
    logic                      r_out_valid;
    logic [ST_W-1:0]           r_out_status;
    logic [LEN_W-1:0]          r_out_length;
    logic                      r_out_found;
    t_out_pos                  r_out_offset;
    t_out_pos                  r_out_count;

    logic                      out_free;
    logic                      advance;
    t_step                     step;
    logic [ST_W-1:0]           st_value;
    logic [LEN_W-1:0]          len_value;
    t_loc_flags                loc_flags;
    logic [POSITION_BITS-1:0]  loc_start;
    logic [POSITION_BITS-1:0]  loc_count;
    logic                      found;
    t_out_pos                  res_offset;
    t_out_pos                  res_count;

    // handshake: a byte moves on unless it is a last byte facing a full result register
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign advance     = r_in_valid && (!r_in_last || out_free);
    assign i_req.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_data <= i_req.data_byte;
            r_in_last <= i_req.last_byte;
        end
    end

    assign step.en   = advance;
    assign step.clr  = r_in_last;
    assign step.data = r_in_data;

    // saturating byte position
    assign n_pos = (&r_pos) ? r_pos : r_pos + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (advance) begin
            r_pos <= r_in_last ? '0 : n_pos;
        end
    end

    // parsers
    hrhe_status u_status (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_value (st_value)
    );

    hrhe_length u_length (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .o_length (len_value)
    );

    hrhe_location #(
        .POSITION_BITS (POSITION_BITS)
    ) u_location (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_pos   (r_pos),
        .o_flags (loc_flags),
        .o_start (loc_start),
        .o_count (loc_count)
    );

    // location fields only count for a redirect
    assign found      = (st_value == ST_REDIRECT) && loc_flags.active;
    assign res_offset = !found ? '0 : (loc_flags.skipping ? t_out_pos'(n_pos)
                                                          : t_out_pos'(loc_start));
    assign res_count  = (found && !loc_flags.skipping) ? t_out_pos'(loc_count) : '0;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_status <= st_value;
            r_out_length <= len_value;
            r_out_found  <= found;
            r_out_offset <= res_offset;
            r_out_count  <= res_count;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.resp_status     = $signed(r_out_status);
    assign o_rsp.content_length  = $signed(r_out_length);
    assign o_rsp.location_found  = r_out_found;
    assign o_rsp.location_offset = r_out_offset;
    assign o_rsp.location_length = r_out_count;

`ifndef SYNTHESIS
    // a processed last byte always leaves a result waiting
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_out_valid)
        else $error("last byte processed without a result");

    // position restarts after every response
    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_pos == '0)
        else $error("byte position not cleared after last byte");

    // an empty input register never blocks a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_req.ready)
        else $error("input stalled with an empty input register");

    // location is reported only for a redirect
    a_found_redirect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_found |-> r_out_status == ST_REDIRECT)
        else $error("location reported for a non-redirect status");

    // no location means zero offset and length
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_found |-> r_out_offset == '0 && r_out_count == '0)
        else $error("location fields set without a location");
`endif

endmodule

/* verif/http_response_header_extractor_test.sv */
// testbench for http_response_header_extractor: random and directed response text,
// a byte-level header parser that predicts each result, and a result checker
// depends on hrhe_pkg, hrhe_in_if, hrhe_out_if and the extractor top level
module http_response_header_extractor_test;
    import hrhe_pkg::*;

    localparam int         STUCK_LIMIT = 500;
    localparam int         POS_W       = POS_BITS_DEF;
    localparam logic [63:0] POS_MAX    = (64'd1 << POS_W) - 64'd1;

    typedef logic [255:0] t_text;

    localparam t_text STATUS_WORD   = "HTTP/1.1";
    localparam t_text LENGTH_WORD   = "Content-Length: ";
    localparam t_text LOCATION_WORD = "Location:";

    // one response byte waiting to be sent
    typedef struct packed {
        logic [7:0] data;
        logic       ends_response;
        logic       drain;
    } t_byte_req;

    // header fields extracted from one response
    typedef struct packed {
        logic [ST_W-1:0]      status;
        logic [LEN_W-1:0]     length;
        logic                 found;
        logic [OUT_POS_W-1:0] loc_offset;
        logic [OUT_POS_W-1:0] loc_length;
    } t_header_fields;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hrhe_in_if  in_ch ();
    hrhe_out_if out_ch ();

    http_response_header_extractor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (in_ch),
        .o_rsp   (out_ch)
    );

    always #10 i_clk = ~i_clk;

    t_byte_req      byte_stream[$];
    t_header_fields pending_headers[$];
    logic [7:0]     resp_buf[$];
    int             error_count = 0;
    int             sent_bytes  = 0;
    int             send_gap    = 0;
    int             stall_left  = 0;
    int             stuck_cycles = 0;

    // parser state of the current response
    logic [63:0] byte_pos;
    int          st_idx;
    t_st_phase   st_phase;
    logic [63:0] st_acc;
    logic        st_neg;
    logic [31:0] st_val;
    int          ln_idx;
    t_len_phase  ln_phase;
    logic [63:0] ln_acc;
    logic        ln_neg;
    int          loc_idx;
    t_loc_phase  loc_phase;
    logic [63:0] loc_start;
    logic [63:0] loc_count;
    logic        cr_seen;

    function automatic logic [7:0] char_at(input t_text word, input int len, input int idx);
        return word[(len - 1 - idx) * 8 +: 8];
    endfunction

    // keyword matcher without fallback beyond the first character
    function automatic int next_match(input int idx, input int len, input t_text word,
                                      input logic [7:0] ch);
        if (idx < len && ch == char_at(word, len, idx))
            return idx + 1;
        return (ch == char_at(word, len, 0)) ? 1 : 0;
    endfunction

    function automatic logic is_decimal(input logic [7:0] ch);
        return ch >= CH_ZERO && ch <= CH_NINE;
    endfunction

    function automatic logic [63:0] add_digit(input logic [63:0] acc, input logic [7:0] ch,
                                              input logic [63:0] limit);
        logic [63:0] d;
        d = {56'd0, ch - CH_ZERO};
        if (acc > (limit - d) / 64'd10)
            return limit;
        return acc * 64'd10 + d;
    endfunction

    task automatic clear_response();
        byte_pos  = 64'd0;
        st_idx    = 0;
        st_phase  = ST_MATCH;
        st_acc    = 64'd0;
        st_neg    = 1'b0;
        ln_idx    = 0;
        ln_phase  = LN_MATCH;
        ln_acc    = 64'd0;
        ln_neg    = 1'b0;
        loc_idx   = 0;
        loc_phase = LC_MATCH;
        loc_start = 64'd0;
        loc_count = 64'd0;
        cr_seen   = 1'b0;
    endtask

    // advance the header parser by one accepted byte, queue a result on the last one
    task automatic parse_response_byte(input logic [7:0] ch, input logic ends_response);
        t_header_fields res;
        logic           st_taken;
        st_taken = 1'b0;

        // status code: keyword, spaces, sign, digits
        if (st_phase == ST_SKIP && ch == CH_SP) begin
            st_taken = 1'b1;
        end else if (st_phase == ST_SKIP && (ch == CH_PLUS || ch == CH_MINUS)) begin
            st_neg   = (ch == CH_MINUS);
            st_phase = ST_SIGN;
            st_taken = 1'b1;
        end else if (st_phase != ST_MATCH) begin
            if (is_decimal(ch)) begin
                if (st_phase != ST_DIGITS)
                    st_acc = 64'd0;
                st_phase = ST_DIGITS;
                st_acc   = add_digit(st_acc, ch, {32'd0, ST_LIMIT});
                if (st_neg)
                    st_val = 32'd0 - st_acc[31:0];
                else
                    st_val = (st_acc > {32'd0, ST_MAX}) ? ST_MAX : st_acc[31:0];
                st_taken = 1'b1;
            end else begin
                st_phase = ST_MATCH;
                st_idx   = 0;
            end
        end
        if (!st_taken) begin
            st_idx = next_match(st_idx, STATUS_KW_LEN, STATUS_WORD, ch);
            if (st_idx == STATUS_KW_LEN) begin
                st_idx   = 0;
                st_phase = ST_SKIP;
                st_neg   = 1'b0;
                st_acc   = 64'd0;
            end
        end

        // content length: first keyword only
        if (ln_phase == LN_MATCH) begin
            ln_idx = next_match(ln_idx, LENGTH_KW_LEN, LENGTH_WORD, ch);
            if (ln_idx == LENGTH_KW_LEN)
                ln_phase = LN_SKIP;
        end else if (ln_phase != LN_DONE && !(ln_phase == LN_SKIP && ch == CH_SP)) begin
            if (ln_phase == LN_SKIP && (ch == CH_PLUS || ch == CH_MINUS)) begin
                ln_neg   = (ch == CH_MINUS);
                ln_phase = LN_SIGN;
            end else if (is_decimal(ch)) begin
                ln_phase = LN_DIGITS;
                ln_acc   = add_digit(ln_acc, ch, LEN_LIMIT);
            end else begin
                ln_phase = LN_DONE;
            end
        end

        // location value span
        if (loc_phase == LC_MATCH) begin
            loc_idx = next_match(loc_idx, LOC_KW_LEN, LOCATION_WORD, ch);
            if (loc_idx == LOC_KW_LEN)
                loc_phase = LC_SKIP;
        end else begin
            if (loc_phase == LC_SKIP && ch != CH_SP) begin
                loc_start = byte_pos;
                loc_count = 64'd0;
                cr_seen   = 1'b0;
                loc_phase = LC_VALUE;
            end
            if (loc_phase == LC_VALUE) begin
                if (cr_seen && ch == CH_LF) begin
                    if (loc_count > 64'd0)
                        loc_count = loc_count - 64'd1;
                    cr_seen   = 1'b0;
                    loc_phase = LC_DONE;
                end else begin
                    if (loc_count < POS_MAX)
                        loc_count = loc_count + 64'd1;
                    cr_seen = (ch == CH_CR);
                end
            end
        end

        if (byte_pos < POS_MAX)
            byte_pos = byte_pos + 64'd1;

        if (ends_response) begin
            res.status = st_val;
            if (ln_neg)
                res.length = 64'd0 - ln_acc;
            else
                res.length = (ln_acc > LEN_MAX) ? LEN_MAX : ln_acc;
            res.found      = (st_val == ST_REDIRECT) && (loc_phase != LC_MATCH);
            res.loc_offset = '0;
            res.loc_length = '0;
            if (res.found) begin
                if (loc_phase == LC_SKIP) begin
                    res.loc_offset = byte_pos[31:0];
                end else begin
                    res.loc_offset = loc_start[31:0];
                    res.loc_length = loc_count[31:0];
                end
            end
            pending_headers.push_back(res);
            clear_response();
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
        end
    endtask

    // response text builders
    task automatic put_word(input t_text word, input int len, input int count);
        for (int i = 0; i < count; i++)
            resp_buf.push_back(char_at(word, len, i));
    endtask

    task automatic put_crlf();
        resp_buf.push_back(CH_CR);
        resp_buf.push_back(CH_LF);
    endtask

    task automatic put_number(input bit wide);
        int n;
        int pick;
        n = $urandom_range(0, 2);
        repeat (n) resp_buf.push_back(CH_SP);
        pick = $urandom_range(0, 9);
        if (pick < 2)
            resp_buf.push_back(CH_MINUS);
        else if (pick < 3)
            resp_buf.push_back(CH_PLUS);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            n = 0;
        else if (pick < 8)
            n = $urandom_range(1, 4);
        else
            n = wide ? $urandom_range(18, 21) : $urandom_range(9, 12);
        repeat (n) resp_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic put_status_line();
        put_word(STATUS_WORD, STATUS_KW_LEN, STATUS_KW_LEN);
        if ($urandom_range(0, 9) < 4) begin
            resp_buf.push_back(CH_SP);
            put_word("302", 3, 3);
        end else begin
            put_number(1'b0);
        end
        if ($urandom_range(0, 3) != 0)
            put_crlf();
    endtask

    task automatic put_length_line();
        put_word(LENGTH_WORD, LENGTH_KW_LEN, LENGTH_KW_LEN);
        put_number(1'b1);
        if ($urandom_range(0, 3) != 0)
            put_crlf();
    endtask

    task automatic put_location_line();
        int n;
        int pick;
        put_word(LOCATION_WORD, LOC_KW_LEN, LOC_KW_LEN);
        n = $urandom_range(0, 2);
        repeat (n) resp_buf.push_back(CH_SP);
        n = $urandom_range(0, 6);
        repeat (n) begin
            pick = $urandom_range(0, 19);
            if (pick < 2)
                resp_buf.push_back(CH_CR);
            else if (pick == 2)
                resp_buf.push_back(CH_LF);
            else
                resp_buf.push_back(8'($urandom_range(33, 126)));
        end
        pick = $urandom_range(0, 9);
        if (pick < 6)
            put_crlf();
        else if (pick < 8)
            resp_buf.push_back(CH_CR);
    endtask

    task automatic put_broken_keyword();
        case ($urandom_range(0, 2))
            0: put_word(STATUS_WORD, STATUS_KW_LEN, $urandom_range(1, STATUS_KW_LEN - 1));
            1: put_word(LENGTH_WORD, LENGTH_KW_LEN, $urandom_range(1, LENGTH_KW_LEN - 1));
            default: put_word(LOCATION_WORD, LOC_KW_LEN, $urandom_range(1, LOC_KW_LEN - 1));
        endcase
    endtask

    // move the built text into the send queue, last byte marked
    task automatic commit_response(input bit drain);
        t_byte_req r;
        if (resp_buf.size() == 0)
            resp_buf.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < resp_buf.size(); i++) begin
            r.data          = resp_buf[i];
            r.ends_response = (i == resp_buf.size() - 1);
            r.drain         = drain && (i == 0);
            byte_stream.push_back(r);
        end
        resp_buf.delete();
    endtask

    task automatic build_random_response(input bit drain);
        int segs;
        int cut;
        segs = $urandom_range(1, 4);
        repeat (segs) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: put_status_line();
                4, 5:       put_length_line();
                6, 7:       put_location_line();
                8:          repeat ($urandom_range(1, 4))
                                resp_buf.push_back(8'($urandom_range(0, 255)));
                default:    put_broken_keyword();
            endcase
        end
        if (resp_buf.size() > 1 && $urandom_range(0, 19) < 3) begin
            cut = $urandom_range(1, resp_buf.size() - 1);
            repeat (cut) void'(resp_buf.pop_back());
        end
        commit_response(drain);
    endtask

    // idling only outside the quiet stretches and the tail of the run
    function automatic bit idling_on();
        return byte_stream.size() > 150 && ((sent_bytes / 200) % 3 != 2);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid     <= 1'b0;
            in_ch.data_byte <= 8'd0;
            in_ch.last_byte <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                parse_response_byte(in_ch.data_byte, in_ch.last_byte);
                sent_bytes++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (byte_stream.size() == 0) begin
                    in_ch.valid <= 1'b0;
                end else if (byte_stream[0].drain && pending_headers.size() != 0) begin
                    in_ch.valid <= 1'b0;
                end else if (idling_on() && $urandom_range(0, 6) == 0) begin
                    send_gap = $urandom_range(0, 3);
                    in_ch.valid <= 1'b0;
                end else begin
                    in_ch.valid     <= 1'b1;
                    in_ch.data_byte <= byte_stream[0].data;
                    in_ch.last_byte <= byte_stream[0].ends_response;
                    void'(byte_stream.pop_front());
                end
            end
        end
    end

    // result monitor and ready stalls
    always @(posedge i_clk) begin
        t_header_fields want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_headers.size() == 0) begin
                    error_count++;
                    $display("%0t unexpected result: expected none actual status %h length %h",
                             $time, out_ch.resp_status, out_ch.content_length);
                end else begin
                    want = pending_headers.pop_front();
                    check_field("resp_status", {32'd0, want.status},
                                {32'd0, out_ch.resp_status});
                    check_field("content_length", want.length, out_ch.content_length);
                    check_field("location_found", {63'd0, want.found},
                                {63'd0, out_ch.location_found});
                    check_field("location_offset", {32'd0, want.loc_offset},
                                {32'd0, out_ch.location_offset});
                    check_field("location_length", {32'd0, want.loc_length},
                                {32'd0, out_ch.location_length});
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idling_on() && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 3);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog on stalled handshakes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == STUCK_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int responses;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'd0;
        in_ch.last_byte = 1'b0;
        out_ch.ready    = 1'b0;
        st_val          = 32'd0;
        clear_response();

        // directed: single-byte responses at both byte extremes
        resp_buf.push_back(8'h00);
        commit_response(1'b0);
        resp_buf.push_back(8'hFF);
        commit_response(1'b0);
        // redirect status ended by a keyword, location keyword ends the response
        put_word("HTTP/1.1 302Location:", 21, 21);
        commit_response(1'b0);
        // status kept from before, location value with trailing cr only
        put_word("Location: a", 11, 11);
        resp_buf.push_back(CH_CR);
        commit_response(1'b0);
        // sign with no digits leaves the status alone
        put_word("HTTP/1.1 -", 10, 10);
        commit_response(1'b0);

        // random responses, draining at the start and once midway
        responses = 0;
        while (byte_stream.size() < 1290 || responses < 40) begin
            build_random_response(responses == 0 || responses == 20);
            responses++;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_stream.size() != 0 || in_ch.valid || pending_headers.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
sv/hrhe_pkg.sv
sv/hrhe_in_if.sv
sv/hrhe_out_if.sv
sv/hrhe_status.sv
sv/hrhe_length.sv
sv/hrhe_location.sv
sv/http_response_header_extractor.sv
verif/http_response_header_extractor_test.sv
